>>> sv/ilha_pkg.sv
package ilha_pkg;
  localparam int HEADER_BYTES = 4;
  localparam int MIN_HEAP     = 32;

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_UNINIT = 2'd1,
    CMD_ALLOC  = 2'd2,
    CMD_FREE   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_F_RD,
    ST_F_CHK,
    ST_F_PRV,
    ST_F_NRD,
    ST_F_NCHK,
    ST_F_WR,
    ST_DONE
  } state_t;
endpackage

>>> sv/ilha_ram.sv
module ilha_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/implicit_list_heap_allocator.sv
// Channel | Direction | Beat contents
// in_     | input     | in_cmd, in_req_size, in_handle
// out_    | output    | out_status, out_payload_offset
// cfg_    | input     | cfg_we, cfg_wdata (heap_size)
//
// Init, uninit and rejected commands put the result out the cycle after the
// beat is taken. Allocate and free walk the block chain one header at a time,
// each header read (ST_A_RD, ST_F_RD) followed by a check (ST_A_CHK, ST_F_CHK).
// A successful free then reads the previous header (ST_F_PRV), may read the
// next header (ST_F_NRD, ST_F_NCHK) and writes in ST_F_WR. Header RAM reads
// are registered. Reset clears control state only; header RAM is not cleared.
// One beat is in flight: in_stall is high until the result is taken.
module implicit_list_heap_allocator #(
  parameter int HEAP_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [12:0] in_req_size,
  input  logic [12:0] in_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [12:0] out_payload_offset,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);
  import ilha_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int SW = AW + 1;          // sizes up to HEAP_BYTES
  localparam int CW = 18;              // room for sums of sizes
  localparam int HW = SW + 1;          // used flag + size

  state_t state_r, state_nxt;
  logic [12:0] heap_size_r;
  logic        ready_r, ready_nxt;
  logic [AW-1:0] sstart_r, sstart_nxt;
  logic [CW-1:0] at_r, at_nxt, prev_r, prev_nxt, blk_r, blk_nxt;
  logic [CW-1:0] bsum_r, bsum_nxt;
  logic        have_prev_r, have_prev_nxt;
  logic        prev_free_r, prev_free_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [CW-1:0] req_r, req_nxt, target_r, target_nxt;
  logic        res_status_r, res_status_nxt;
  logic [12:0] res_off_r, res_off_nxt;
  logic [CW-1:0] size_c, end_c;

  // Second RAM write for split / merge is queued into a pending slot.
  logic        pend_r, pend_nxt;
  logic [AW-1:0] pend_a_r, pend_a_nxt;
  logic [HW-1:0] pend_d_r, pend_d_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [HW-1:0] wdata, rdata;
  logic          r_used;
  logic [CW-1:0] r_size;

  ilha_ram #(.WIDTH(HW), .DEPTH(HEAP_BYTES)) u_hdr (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign r_used = rdata[HW-1];
  assign r_size = CW'(rdata[SW-1:0]);
  assign size_c = (CW'(heap_size_r) > CW'(HEAP_BYTES)) ? CW'(HEAP_BYTES)
                                                       : CW'(heap_size_r);
  assign end_c  = size_c - CW'(HEADER_BYTES);

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = (state_r == ST_DONE);
  assign out_status         = res_status_r;
  assign out_payload_offset = res_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      heap_size_r <= 13'd4096;
      ready_r     <= 1'b0;
      sstart_r    <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ready_r  <= cfg_we ? 1'b0 : ready_nxt;
      sstart_r <= sstart_nxt;
      pend_r   <= pend_nxt;
      if (cfg_we) begin
        heap_size_r <= cfg_wdata;
      end
    end
    at_r         <= at_nxt;
    prev_r       <= prev_nxt;
    blk_r        <= blk_nxt;
    bsum_r       <= bsum_nxt;
    have_prev_r  <= have_prev_nxt;
    prev_free_r  <= prev_free_nxt;
    steps_r      <= steps_nxt;
    req_r        <= req_nxt;
    target_r     <= target_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    pend_a_r     <= pend_a_nxt;
    pend_d_r     <= pend_d_nxt;
  end

  always_comb begin
    logic [CW-1:0] keep, rest;
    state_nxt      = state_r;
    ready_nxt      = ready_r;
    sstart_nxt     = sstart_r;
    at_nxt         = at_r;
    prev_nxt       = prev_r;
    blk_nxt        = blk_r;
    bsum_nxt       = bsum_r;
    have_prev_nxt  = have_prev_r;
    prev_free_nxt  = prev_free_r;
    steps_nxt      = steps_r;
    req_nxt        = req_r;
    target_nxt     = target_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    pend_nxt       = 1'b0;
    pend_a_nxt     = pend_a_r;
    pend_d_nxt     = pend_d_r;
    we             = pend_r;
    waddr          = pend_a_r;
    wdata          = pend_d_r;
    raddr          = at_r[AW-1:0];
    keep           = req_r + CW'(HEADER_BYTES);
    rest           = at_r + keep;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_status_nxt = 1'b1;
          res_off_nxt    = '0;
          req_nxt        = CW'(in_req_size);
          at_nxt         = '0;
          steps_nxt      = '0;
          have_prev_nxt  = 1'b0;
          state_nxt      = ST_DONE;
          if (size_c >= CW'(MIN_HEAP)) begin
            case (cmd_t'(in_cmd))
              CMD_INIT: begin
                // Fold the init write into the pending slot.
                pend_nxt       = 1'b1;
                pend_a_nxt     = '0;
                pend_d_nxt     = {1'b0, SW'(size_c)};
                sstart_nxt     = '0;
                ready_nxt      = 1'b1;
                res_status_nxt = 1'b0;
              end
              CMD_UNINIT: begin
                ready_nxt      = 1'b0;
                res_status_nxt = 1'b0;
              end
              CMD_ALLOC: begin
                if (ready_r && in_req_size != '0) begin
                  at_nxt    = CW'(sstart_r);
                  state_nxt = ST_A_RD;
                end
              end
              default: begin
                if (ready_r && CW'(in_handle) >= CW'(HEADER_BYTES) &&
                    CW'(in_handle) <= size_c) begin
                  target_nxt = CW'(in_handle) - CW'(HEADER_BYTES);
                  state_nxt  = ST_F_RD;
                end
              end
            endcase
          end
        end
      end
      ST_A_RD: begin
        // Issue read of the header at at_r, or stop at end of the walk.
        if (steps_r >= CW'(HEAP_BYTES) || at_r >= end_c ||
            at_r >= CW'(HEAP_BYTES)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        steps_nxt = steps_r + CW'(1);
        if (r_size == '0) begin
          state_nxt = ST_DONE;
        end else if (!r_used && r_size >= keep + CW'(HEADER_BYTES)) begin
          we = 1'b1;
          waddr = at_r[AW-1:0];
          if (rest < end_c) begin
            wdata      = {1'b1, SW'(keep)};
            pend_nxt   = 1'b1;
            pend_a_nxt = rest[AW-1:0];
            pend_d_nxt = {1'b0, SW'(r_size - keep)};
            sstart_nxt = rest[AW-1:0];
          end else begin
            wdata      = {1'b1, SW'(end_c - at_r)};
            sstart_nxt = '0;
          end
          res_status_nxt = 1'b0;
          res_off_nxt    = 13'(at_r + CW'(HEADER_BYTES));
          state_nxt      = ST_DONE;
        end else begin
          at_nxt    = at_r + r_size;
          state_nxt = ST_A_RD;
        end
      end
      ST_F_RD: begin
        if (steps_r >= CW'(HEAP_BYTES) || at_r >= end_c ||
            at_r >= CW'(HEAP_BYTES)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_F_CHK;
        end
      end
      ST_F_CHK: begin
        steps_nxt = steps_r + CW'(1);
        if (at_r == target_r) begin
          bsum_nxt  = r_size;
          blk_nxt   = at_r;
          state_nxt = ST_F_PRV;
          raddr     = prev_r[AW-1:0];
        end else if (r_size == '0) begin
          state_nxt = ST_DONE;
        end else begin
          prev_nxt      = at_r;
          have_prev_nxt = 1'b1;
          at_nxt        = at_r + r_size;
          state_nxt     = ST_F_RD;
        end
      end
      ST_F_PRV: begin
        // rdata holds the previous header; merge into it when free.
        prev_free_nxt = have_prev_r && !r_used;
        if (have_prev_r && !r_used) begin
          blk_nxt  = prev_r;
          bsum_nxt = r_size + bsum_r;
        end
        at_nxt    = at_r + bsum_r;
        state_nxt = ST_F_NRD;
      end
      ST_F_NRD: begin
        if (at_r < end_c && at_r < CW'(HEAP_BYTES)) begin
          state_nxt = ST_F_NCHK;
        end else begin
          state_nxt = ST_F_WR;
        end
      end
      ST_F_NCHK: begin
        if (!r_used) begin
          bsum_nxt = bsum_r + r_size;
        end
        state_nxt = ST_F_WR;
      end
      ST_F_WR: begin
        // Clear the target's used flag. When absorbed by the previous block
        // the target keeps its own size (at_r still sits just past it) and
        // the merged size goes to the previous header through the pending slot.
        we    = 1'b1;
        waddr = target_r[AW-1:0];
        if (prev_free_r) begin
          wdata      = {1'b0, SW'(at_r - target_r)};
          pend_nxt   = 1'b1;
          pend_a_nxt = blk_r[AW-1:0];
          pend_d_nxt = {1'b0, SW'(bsum_r)};
        end else begin
          wdata      = {1'b0, SW'(bsum_r)};
        end
        if (blk_r < CW'(sstart_r)) begin
          sstart_nxt = blk_r[AW-1:0];
        end
        res_status_nxt = 1'b0;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

>>> sv/ilha_checker.sv
module ilha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_status,
  input logic [12:0] out_payload_offset
);
  // A failed result carries offset zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_payload_offset == '0)
    else $error("failure with nonzero offset");

  // Result holds while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_offset))
    else $error("result dropped under stall");

  // No new beat accepted while a result is pending.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // A taken beat closes the input until its result leaves.
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not closed after a beat");

  // Successful allocation returns a payload past the first header.
  a_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status && out_payload_offset != '0 |->
      out_payload_offset >= 13'd4)
    else $error("offset inside header");
endmodule

bind implicit_list_heap_allocator ilha_checker u_ilha_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_payload_offset(out_payload_offset)
);
